@@ rtl/core/dva_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the dual encoder velocity averager.
// No dependencies; every module of the block imports this package.
package dva_pkg;

   // Fixed field widths
   localparam int COUNT_W    = 32;
   localparam int DELTA_W    = 8;
   localparam int MM_W       = 16;
   localparam int LPS_W      = 16;
   localparam int CHANGE_W   = 24;
   localparam int SPEED_W    = 40;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // Saturation bounds of a wheel delta
   localparam logic signed [COUNT_W-1:0] DELTA_MAX = 32'sd127;
   localparam logic signed [COUNT_W-1:0] DELTA_MIN = -32'sd128;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MM_PER_TICK  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOPS_PER_S  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_ENABLE  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_ENABLE = 4'd3;

   // Register reset values
   localparam logic [MM_W-1:0]  MM_PER_TICK_RESET = 16'd1000;
   localparam logic [LPS_W-1:0] LOOPS_PER_S_RESET = 16'd500;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MULT,
      ST_RECIP,
      ST_FIX,
      ST_MERGE
   } dva_state_type;

   // Step strobes sent to each wheel lane
   typedef struct packed {
      logic load;
      logic update;
      logic mult;
      logic recip;
      logic fix;
   } dva_step_type;

endpackage

@@ rtl/core/dual_encoder_velocity_averager.sv @@
`timescale 1ns / 1ps
// Top level of the dual encoder velocity averager: registers, sequencer,
// two wheel lanes and the merge stage. Uses dva_pkg, dva_lane, dva_merge.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  left and right absolute counts
//   rsp_     out        rsp_valid/rsp_stall  changes, forward change, speeds, clip
//   csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
// A request is accepted in the idle step and its result is loaded into the
// output register after ring update, multiply, reciprocal multiply, quotient
// fix and merge; each request walks all six sequencer steps, and no new
// request is taken until the previous one has left the merge step.
// The next request is taken while the result waits in the output register.
// A stalled result holds the sequencer in its merge step.
// Reset is synchronous; the delta ring needs no clearing pass, as the oldest
// entry is not subtracted from the total until the ring position first wraps.
module dual_encoder_velocity_averager import dva_pkg::*; #(
   parameter int AVERAGE_TAPS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [COUNT_W-1:0]  req_left_count,
   input  logic signed [COUNT_W-1:0]  req_right_count,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [CHANGE_W-1:0] rsp_left_change_q16,
   output logic signed [CHANGE_W-1:0] rsp_right_change_q16,
   output logic signed [CHANGE_W-1:0] rsp_forward_change_q16,
   output logic signed [SPEED_W-1:0]  rsp_left_speed_q16,
   output logic signed [SPEED_W-1:0]  rsp_right_speed_q16,
   output logic                       rsp_delta_clipped,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data
);

   localparam int PW = $clog2(AVERAGE_TAPS);

   dva_state_type          state_ff, state_in;
   dva_step_type           step;
   logic [MM_W-1:0]        mm_ff;
   logic [LPS_W-1:0]       lps_ff;
   logic                   len_ff, ren_ff;
   logic [PW-1:0]          pos_ff, pos_in;
   logic                   wrapped_ff, wrapped_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept, out_load;
   logic signed [CHANGE_W-1:0] lchange, rchange;
   logic                   lclip, rclip;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mm_ff  <= MM_PER_TICK_RESET;
         lps_ff <= LOOPS_PER_S_RESET;
         len_ff <= 1'b1;
         ren_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MM_PER_TICK:  mm_ff  <= csr_data;
            CSR_LOOPS_PER_S:  lps_ff <= csr_data;
            CSR_LEFT_ENABLE:  len_ff <= csr_data[0];
            CSR_RIGHT_ENABLE: ren_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state and step strobes
   always_comb begin
      state_in    = state_ff;
      accept      = 1'b0;
      out_load    = 1'b0;
      step        = '0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               accept    = 1'b1;
               step.load = 1'b1;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            step.update = 1'b1;
            state_in    = ST_MULT;
         end
         ST_MULT: begin
            step.mult = 1'b1;
            state_in  = ST_RECIP;
         end
         ST_RECIP: begin
            step.recip = 1'b1;
            state_in   = ST_FIX;
         end
         ST_FIX: begin
            step.fix = 1'b1;
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Ring position advances once per request
   always_comb begin
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      if (step.update) begin
         if (pos_ff == PW'(AVERAGE_TAPS - 1)) begin
            pos_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   dva_lane #(.TAPS(AVERAGE_TAPS)) u_left (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .count       (req_left_count),
      .enable      (len_ff),
      .tick_scale  (mm_ff),
      .pos         (pos_ff),
      .wrapped     (wrapped_ff),
      .change      (lchange),
      .clip        (lclip)
   );

   dva_lane #(.TAPS(AVERAGE_TAPS)) u_right (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .count       (req_right_count),
      .enable      (ren_ff),
      .tick_scale  (mm_ff),
      .pos         (pos_ff),
      .wrapped     (wrapped_ff),
      .change      (rchange),
      .clip        (rclip)
   );

   dva_merge u_merge (
      .clock              (clock),
      .load               (out_load),
      .left_travel        (lchange),
      .right_travel       (rchange),
      .left_clip          (lclip),
      .right_clip         (rclip),
      .loops_per_second   (lps_ff),
      .left_travel_q16    (rsp_left_change_q16),
      .right_travel_q16   (rsp_right_change_q16),
      .forward_change_q16 (rsp_forward_change_q16),
      .left_speed_q16     (rsp_left_speed_q16),
      .right_speed_q16    (rsp_right_speed_q16),
      .delta_clipped      (rsp_delta_clipped)
   );

   assign rsp_valid = rsp_valid_ff;

   // An accepted request always starts the ring update next
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_UPDATE)
      else $error("accepted request did not start ring update");

   // A new result only appears out of the merge step
   a_result_from_merge: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_MERGE))
      else $error("result appeared outside merge step");

   // Ring position stays inside the window
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(AVERAGE_TAPS - 1))
      else $error("ring position out of range");

   // Once wrapped, the ring stays fully populated
   a_wrapped_sticky: assert property (@(posedge clock) disable iff (reset)
      wrapped_ff |=> wrapped_ff)
      else $error("ring wrap flag cleared");

   // Position moves only during the update step
   a_pos_moves_on_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_UPDATE) |=> $stable(pos_ff))
      else $error("ring position moved outside update");

endmodule

@@ rtl/core/dva_lane.sv @@
`timescale 1ns / 1ps
// One wheel lane: delta and saturation, delta ring with running total,
// scaling by travel per tick and division by the tap count. Uses dva_pkg.
module dva_lane import dva_pkg::*; #(
   parameter int TAPS = 8,
   localparam int PW  = $clog2(TAPS),
   localparam int TW  = DELTA_W + PW,
   localparam int MW  = TW + 15
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dva_step_type               step,
   input  logic signed [COUNT_W-1:0]  count,
   input  logic                       enable,
   input  logic [MM_W-1:0]            tick_scale,
   input  logic [PW-1:0]              pos,
   input  logic                       wrapped,
   output logic signed [CHANGE_W-1:0] change,
   output logic                       clip
);

   // floor(2^32 / TAPS); the quotient estimate is at most one low
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TAPS);

   logic [COUNT_W-1:0]        last_ff, last_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic                      clip_ff, clip_in;
   logic signed [DELTA_W-1:0] rd_ff;
   logic signed [TW-1:0]      total_ff, total_in;
   logic [MW-1:0]             mag_ff, mag_in;
   logic                      neg_ff;
   logic [MW+31:0]            recip_ff, recip_in;
   logic signed [CHANGE_W-1:0] change_ff, change_in;
   logic signed [DELTA_W-1:0] ring_mem [TAPS];

   logic signed [COUNT_W-1:0] diff;
   logic [TW-1:0]             abs_total;
   logic [MW-1:0]             q0, back, rem, q;

   // Wrapping difference, saturated to the delta range
   always_comb begin
      diff     = count - $signed(last_ff);
      last_in  = last_ff;
      delta_in = '0;
      clip_in  = 1'b0;
      if (enable) begin
         last_in = count;
         if (diff > DELTA_MAX) begin
            delta_in = DELTA_MAX[DELTA_W-1:0];
            clip_in  = 1'b1;
         end else if (diff < DELTA_MIN) begin
            delta_in = DELTA_MIN[DELTA_W-1:0];
            clip_in  = 1'b1;
         end else begin
            delta_in = diff[DELTA_W-1:0];
         end
      end
   end

   // Running total: drop the oldest delta once the ring has wrapped
   always_comb begin
      total_in = total_ff + TW'(delta_ff);
      if (wrapped) begin
         total_in = total_in - TW'(rd_ff);
      end
   end

   // Magnitude of total times travel per tick
   always_comb begin
      abs_total = total_ff[TW-1] ? TW'(-total_ff) : TW'(total_ff);
      mag_in    = MW'(abs_total * tick_scale);
   end

   assign recip_in = (MW+32)'(mag_ff) * (MW+32)'(RECIP);

   // Correct the quotient estimate and restore the sign
   always_comb begin
      q0   = recip_ff[MW+31:32];
      back = MW'(q0 * TAPS);
      rem  = mag_ff - back;
      q    = (rem >= MW'(TAPS)) ? q0 + 1'b1 : q0;
      change_in = neg_ff ? -$signed(q[CHANGE_W-1:0]) : $signed(q[CHANGE_W-1:0]);
   end

   // Lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         total_ff <= '0;
         clip_ff  <= 1'b0;
      end else begin
         if (step.load) begin
            last_ff <= last_in;
            clip_ff <= clip_in;
         end
         if (step.update) begin
            total_ff <= total_in;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (step.load) begin
         delta_ff <= delta_in;
      end
      if (step.mult) begin
         mag_ff <= mag_in;
         neg_ff <= total_ff[TW-1];
      end
      if (step.recip) begin
         recip_ff <= recip_in;
      end
      if (step.fix) begin
         change_ff <= change_in;
      end
   end

   // Delta ring: read the oldest entry on load, overwrite it on update
   always_ff @(posedge clock) begin
      if (step.load) begin
         rd_ff <= ring_mem[pos];
      end
      if (step.update) begin
         ring_mem[pos] <= delta_ff;
      end
   end

   assign change = change_ff;
   assign clip   = clip_ff;

endmodule

@@ rtl/core/dva_merge.sv @@
`timescale 1ns / 1ps
// Merge stage: per-wheel travel, forward mean, per-wheel speed and clip flag,
// registered as the result payload. Uses dva_pkg.
module dva_merge import dva_pkg::*; (
   input  logic                       clock,
   input  logic                       load,
   input  logic signed [CHANGE_W-1:0] left_travel,
   input  logic signed [CHANGE_W-1:0] right_travel,
   input  logic                       left_clip,
   input  logic                       right_clip,
   input  logic [LPS_W-1:0]           loops_per_second,
   output logic signed [CHANGE_W-1:0] left_travel_q16,
   output logic signed [CHANGE_W-1:0] right_travel_q16,
   output logic signed [CHANGE_W-1:0] forward_change_q16,
   output logic signed [SPEED_W-1:0]  left_speed_q16,
   output logic signed [SPEED_W-1:0]  right_speed_q16,
   output logic                       delta_clipped
);

   logic signed [CHANGE_W-1:0]  left_ff, right_ff, fwd_ff;
   logic signed [SPEED_W-1:0]   lspd_ff, rspd_ff;
   logic                        clip_ff;
   logic signed [CHANGE_W:0]    sum;
   logic signed [LPS_W:0]       lps_s;
   logic signed [CHANGE_W+LPS_W:0] lspd_full, rspd_full;

   // Floor mean and speed products
   always_comb begin
      sum       = (CHANGE_W+1)'(left_travel) + (CHANGE_W+1)'(right_travel);
      lps_s     = $signed({1'b0, loops_per_second});
      lspd_full = left_travel * lps_s;
      rspd_full = right_travel * lps_s;
   end

   // Hold the payload until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         left_ff  <= left_travel;
         right_ff <= right_travel;
         fwd_ff   <= sum[CHANGE_W:1];
         lspd_ff  <= lspd_full[SPEED_W-1:0];
         rspd_ff  <= rspd_full[SPEED_W-1:0];
         clip_ff  <= left_clip | right_clip;
      end
   end

   assign left_travel_q16    = left_ff;
   assign right_travel_q16   = right_ff;
   assign forward_change_q16 = fwd_ff;
   assign left_speed_q16     = lspd_ff;
   assign right_speed_q16    = rspd_ff;
   assign delta_clipped      = clip_ff;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for dual_encoder_velocity_averager: directed ticks, then random
// encoder traces under several register settings and idle patterns. Imports dva_pkg.
module tb import dva_pkg::*; ();

   localparam int TAPS      = 8;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE    = 12;

   typedef struct {
      logic signed [CHANGE_W-1:0] left_travel;
      logic signed [CHANGE_W-1:0] right_travel;
      logic signed [CHANGE_W-1:0] forward_change;
      logic signed [SPEED_W-1:0]  left_speed;
      logic signed [SPEED_W-1:0]  right_speed;
      logic                       clipped;
   } velocity_type;

   typedef enum { ROW_TICK, ROW_SETUP } row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [COUNT_W-1:0] left;
      logic [COUNT_W-1:0] right;
      logic [MM_W-1:0]   mm;
      logic [LPS_W-1:0]  lps;
      logic              left_on;
      logic              right_on;
      logic              typed;
      velocity_type      result;
   } stim_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [COUNT_W-1:0]         req_left_count = '0;
   logic [COUNT_W-1:0]         req_right_count = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [CHANGE_W-1:0] rsp_left_change_q16;
   logic signed [CHANGE_W-1:0] rsp_right_change_q16;
   logic signed [CHANGE_W-1:0] rsp_forward_change_q16;
   logic signed [SPEED_W-1:0]  rsp_left_speed_q16;
   logic signed [SPEED_W-1:0]  rsp_right_speed_q16;
   logic                       rsp_delta_clipped;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   // Shadow registers and averaging state
   logic [MM_W-1:0]    mm_cfg = MM_PER_TICK_RESET;
   logic [LPS_W-1:0]   lps_cfg = LOOPS_PER_S_RESET;
   logic               left_on_cfg = 1'b1;
   logic               right_on_cfg = 1'b1;
   logic [COUNT_W-1:0] left_prev = '0;
   logic [COUNT_W-1:0] right_prev = '0;
   int                 left_ring [TAPS];
   int                 right_ring [TAPS];
   int                 left_total = 0;
   int                 right_total = 0;
   int                 ring_slot = 0;

   velocity_type  velocity_due [$];
   stim_row_type  plan [$];
   int            mismatch_count = 0;
   int unsigned   sender_idle_pct = 0;
   int unsigned   rsp_idle_pct = 0;
   bit            hold_start = 1'b0;

   dual_encoder_velocity_averager uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_left_count         (req_left_count),
      .req_right_count        (req_right_count),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_left_change_q16    (rsp_left_change_q16),
      .rsp_right_change_q16   (rsp_right_change_q16),
      .rsp_forward_change_q16 (rsp_forward_change_q16),
      .rsp_left_speed_q16     (rsp_left_speed_q16),
      .rsp_right_speed_q16    (rsp_right_speed_q16),
      .rsp_delta_clipped      (rsp_delta_clipped),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("dual_encoder_velocity_averager regression: fail");
      $finish;
   end

   initial begin
      for (int i = 0; i < TAPS; i++) begin
         left_ring[i] = 0;
         right_ring[i] = 0;
      end
   end

   // Clamp a wrapped count difference to the 8-bit delta range
   function automatic int saturate_delta(input logic signed [COUNT_W-1:0] diff);
      if (diff > DELTA_MAX) return DELTA_MAX;
      if (diff < DELTA_MIN) return DELTA_MIN;
      return diff;
   endfunction

   // Advance the averaging state by one tick and work out its velocity
   function automatic velocity_type average_velocity(input logic [COUNT_W-1:0] left_now,
                                                     input logic [COUNT_W-1:0] right_now);
      velocity_type               res;
      int                         dl;
      int                         dr;
      logic signed [COUNT_W-1:0] raw;
      longint                     lc;
      longint                     rc;
      longint                     sum;
      res.clipped = 1'b0;
      dl = 0;
      dr = 0;
      if (left_on_cfg) begin
         raw = left_now - left_prev;
         left_prev = left_now;
         dl = saturate_delta(raw);
         if (dl != raw) res.clipped = 1'b1;
      end
      if (right_on_cfg) begin
         raw = right_now - right_prev;
         right_prev = right_now;
         dr = saturate_delta(raw);
         if (dr != raw) res.clipped = 1'b1;
      end
      left_total = left_total - left_ring[ring_slot] + dl;
      right_total = right_total - right_ring[ring_slot] + dr;
      left_ring[ring_slot] = dl;
      right_ring[ring_slot] = dr;
      ring_slot = (ring_slot + 1) % TAPS;
      // Division truncates toward zero, the mean rounds toward minus infinity
      lc = (longint'(left_total) * longint'(mm_cfg)) / TAPS;
      rc = (longint'(right_total) * longint'(mm_cfg)) / TAPS;
      sum = lc + rc;
      res.left_travel = lc[CHANGE_W-1:0];
      res.right_travel = rc[CHANGE_W-1:0];
      res.forward_change = sum[CHANGE_W:1];
      lc = lc * longint'(lps_cfg);
      rc = rc * longint'(lps_cfg);
      res.left_speed = lc[SPEED_W-1:0];
      res.right_speed = rc[SPEED_W-1:0];
      return res;
   endfunction

   function automatic stim_row_type tick_row(input logic [COUNT_W-1:0] left,
                                             input logic [COUNT_W-1:0] right);
      stim_row_type row;
      row.kind = ROW_TICK;
      row.left = left;
      row.right = right;
      row.mm = '0;
      row.lps = '0;
      row.left_on = 1'b0;
      row.right_on = 1'b0;
      row.typed = 1'b0;
      return row;
   endfunction

   function automatic stim_row_type known_row(input logic [COUNT_W-1:0] left,
                                              input logic [COUNT_W-1:0] right,
                                              input longint lc, input longint rc,
                                              input longint fc, input longint ls,
                                              input longint rs, input logic clip);
      stim_row_type row;
      row = tick_row(left, right);
      row.typed = 1'b1;
      row.result.left_travel = lc[CHANGE_W-1:0];
      row.result.right_travel = rc[CHANGE_W-1:0];
      row.result.forward_change = fc[CHANGE_W-1:0];
      row.result.left_speed = ls[SPEED_W-1:0];
      row.result.right_speed = rs[SPEED_W-1:0];
      row.result.clipped = clip;
      return row;
   endfunction

   function automatic stim_row_type setup_row(input logic [MM_W-1:0] mm,
                                              input logic [LPS_W-1:0] lps,
                                              input logic left_on, input logic right_on);
      stim_row_type row;
      row = tick_row('0, '0);
      row.kind = ROW_SETUP;
      row.mm = mm;
      row.lps = lps;
      row.left_on = left_on;
      row.right_on = right_on;
      return row;
   endfunction

   // Next count of one wheel: mostly a plausible step, sometimes a jump or noise
   function automatic logic [COUNT_W-1:0] next_count(input logic [COUNT_W-1:0] cur);
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 75) return cur + $urandom_range(254) - 127;
      if (pick < 85) return cur + $urandom_range(300) - 150;
      if (pick < 92) return $urandom();
      if (pick < 96) return 32'h7FFF_FF80 + $urandom_range(255);
      return cur + $urandom();
   endfunction

   // Write one register and mirror it in the shadow copy
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MM_PER_TICK:  mm_cfg = value;
         CSR_LOOPS_PER_S:  lps_cfg = value;
         CSR_LEFT_ENABLE:  left_on_cfg = value[0];
         CSR_RIGHT_ENABLE: right_on_cfg = value[0];
         default: ;
      endcase
   endtask

   // Write every register, plus one unmapped index that must change nothing
   task automatic configure(input logic [MM_W-1:0] mm, input logic [LPS_W-1:0] lps,
                            input logic left_on, input logic right_on);
      write_reg(CSR_MM_PER_TICK, mm);
      write_reg(CSR_LOOPS_PER_S, lps);
      write_reg(CSR_LEFT_ENABLE, {15'($urandom()), left_on});
      write_reg(CSR_RIGHT_ENABLE, {15'($urandom()), right_on});
      write_reg(CSR_IDX_W'($urandom_range(15, 4)), 16'($urandom()));
      csr_valid <= 1'b0;
   endtask

   // Drop the request, wait out every pending result, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (velocity_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Offer one request after a random idle gap and predict it once taken
   task automatic send_tick(input logic [COUNT_W-1:0] left, input logic [COUNT_W-1:0] right,
                            output velocity_type predicted);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_left_count <= left;
      req_right_count <= right;
      do @(posedge clock); while (req_stall);
      predicted = average_velocity(left, right);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Receiver: random stalls, or one long hold-off when asked
   initial begin : rsp_driver
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_stall <= !reset && ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : rsp_check
      velocity_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (velocity_due.size() == 0) begin
            $display("%0t unexpected result: expected none, got left change %0d", $time,
                     rsp_left_change_q16);
            mismatch_count++;
         end else begin
            want = velocity_due.pop_front();
            check_field("left_travel", want.left_travel, rsp_left_change_q16);
            check_field("right_travel", want.right_travel, rsp_right_change_q16);
            check_field("forward_change", want.forward_change, rsp_forward_change_q16);
            check_field("left_speed", want.left_speed, rsp_left_speed_q16);
            check_field("right_speed", want.right_speed, rsp_right_speed_q16);
            check_field("delta_clipped", want.clipped, rsp_delta_clipped);
         end
      end
   end

   initial begin : stimulus
      velocity_type       pred;
      logic [COUNT_W-1:0] left_gen;
      logic [COUNT_W-1:0] right_gen;
      logic [MM_W-1:0]    mm;
      logic [LPS_W-1:0]   lps;
      logic               left_on;
      logic               right_on;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed ticks: reset values, wrap, delta bounds, ring wrap, registers
      plan.push_back(known_row(32'h0, 32'h0, 0, 0, 0, 0, 0, 1'b0));
      plan.push_back(known_row(32'h7FFF_FFFF, 32'h8000_0000, 15875, -16000, -63,
                               7937500, -8000000, 1'b1));
      plan.push_back(tick_row(32'h8000_0000, 32'h7FFF_FFFF));
      plan.push_back(tick_row(32'h8000_007F, 32'h7FFF_FF7F));
      plan.push_back(tick_row(32'h8000_0100, 32'h7FFF_FEFE));
      for (int k = 1; k <= 6; k++)
         plan.push_back(tick_row(32'h8000_0100 + k * 127, 32'h7FFF_FEFE - k * 128));
      // Left off at full scale: jumps ignored, right fills the ring at the floor
      plan.push_back(setup_row(16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
      for (int k = 1; k <= 9; k++)
         plan.push_back(tick_row($urandom(), 32'h7FFF_FEFE - (6 + k) * 128));
      // Zero scale and zero loop rate, right off
      plan.push_back(setup_row(16'h0, 16'h0, 1'b1, 1'b0));
      for (int k = 0; k < 4; k++)
         plan.push_back(tick_row($urandom(), $urandom()));

      sender_idle_pct = 12;
      rsp_idle_pct = 79;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_SETUP) begin
            drain();
            configure(plan[i].mm, plan[i].lps, plan[i].left_on, plan[i].right_on);
         end else begin
            send_tick(plan[i].left, plan[i].right, pred);
            velocity_due.push_back(plan[i].typed ? plan[i].result : pred);
         end
      end

      // Random traces: three idle patterns, four register settings each
      left_gen = $urandom();
      right_gen = $urandom();
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin sender_idle_pct = 12; rsp_idle_pct = 79; end
            1: begin sender_idle_pct = 79; rsp_idle_pct = 12; end
            default: begin sender_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            left_on = 1'($urandom_range(1));
            right_on = 1'($urandom_range(1));
            case (seg)
               0: begin
                  mm = 16'($urandom());
                  lps = 16'($urandom());
                  left_on = 1'b1;
                  right_on = 1'b1;
               end
               1: begin mm = 16'hFFFF; lps = 16'hFFFF; left_on = 1'b1; right_on = 1'b1; end
               2: begin mm = 16'h0; lps = 16'h1; end
               default: begin mm = 16'($urandom()); lps = 16'h0; end
            endcase
            drain();
            configure(mm, lps, left_on, right_on);
            // Hold the receiver off long enough to back up the input
            if (mode == 2 && seg == 0) hold_start = 1'b1;
            repeat (92) begin
               left_gen = next_count(left_gen);
               right_gen = next_count(right_gen);
               send_tick(left_gen, right_gen, pred);
               velocity_due.push_back(pred);
            end
         end
      end

      drain();
      if (mismatch_count == 0 && velocity_due.size() == 0) begin
         $display("dual_encoder_velocity_averager regression: pass");
      end else begin
         $display("dual_encoder_velocity_averager regression: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/dva_pkg.sv
rtl/core/dva_lane.sv
rtl/core/dva_merge.sv
rtl/core/dual_encoder_velocity_averager.sv
bench/tb.sv
